FILE: hdl/fatvcm_pkg.sv
// ---------------------------------------------------------------------------
// fatvcm_pkg
// Shared types and constants for the FAT volume cluster mapper.
// ---------------------------------------------------------------------------
`default_nettype none

package fatvcm_pkg;

  localparam int unsigned BpsW = 13;
  localparam int unsigned SpcW = 8;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BYTES_PER_SECTOR    = 3'd0,
    REG_SECTORS_PER_CLUSTER = 3'd1,
    REG_RESERVED_SECTORS    = 3'd2,
    REG_TABLE_COPIES        = 3'd3,
    REG_TABLE_SIZE_SECTORS  = 3'd4,
    REG_ROOT_ENTRY_COUNT    = 3'd5,
    REG_TOTAL_SECTORS       = 3'd6
  } reg_index_e;

  localparam logic [12:0] RstBytesPerSector   = 13'd512;
  localparam logic [7:0]  RstSectorsPerCluster = 8'd1;
  localparam logic [15:0] RstReservedSectors  = 16'd1;
  localparam logic [7:0]  RstTableCopies      = 8'd2;
  localparam logic [31:0] RstTableSizeSectors = 32'd9;
  localparam logic [15:0] RstRootEntryCount   = 16'd224;
  localparam logic [31:0] RstTotalSectors     = 32'd2880;

  localparam logic [31:0] Fat12Limit = 32'd4085;
  localparam logic [31:0] Fat16Limit = 32'd65525;

  localparam logic [15:0] F16Free     = 16'h0000;
  localparam logic [15:0] F16DataLo   = 16'h0002;
  localparam logic [15:0] F16DataHi   = 16'hFFF6;
  localparam logic [15:0] F16EndLo    = 16'hFFF8;
  localparam logic [27:0] F32Free     = 28'h0000000;
  localparam logic [27:0] F32DataLo   = 28'h0000002;
  localparam logic [27:0] F32DataHi   = 28'hFFFFFF6;
  localparam logic [27:0] F32EndLo    = 28'hFFFFFF8;

  typedef enum logic [1:0] {
    KIND_FAT12 = 2'd0,
    KIND_FAT16 = 2'd1,
    KIND_FAT32 = 2'd2,
    KIND_EXFAT = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CLASS_ERROR    = 3'd0,
    CLASS_FREE     = 3'd1,
    CLASS_DATA     = 3'd2,
    CLASS_RESERVED = 3'd3,
    CLASS_END      = 3'd4
  } class_e;

  typedef enum logic [2:0] {
    G_START,
    G_ROOT,
    G_MUL,
    G_SUM,
    G_CLUS,
    G_KIND,
    G_DONE
  } geom_state_e;

  typedef struct packed {
    logic        action;
    logic [27:0] cluster;
    logic [31:0] table_word;
  } req_t;

  typedef struct packed {
    logic [1:0]  volume_kind;
    logic [31:0] entry_address;
    logic [31:0] data_address;
    logic [2:0]  entry_class;
    logic [27:0] next_cluster;
  } res_t;

  typedef struct packed {
    logic             ready;
    kind_e            kind;
    logic [31:0]      first_data;
    logic [31:0]      table_base;
    logic [BpsW-1:0]  bps;
    logic [SpcW-1:0]  spc;
  } geom_t;

endpackage

`default_nettype wire

FILE: hdl/fatvcm_geom.sv
// ---------------------------------------------------------------------------
// fatvcm_geom
// Geometry registers and the serial unit that derives root size, first data
// sector, cluster count and volume kind after every register write.
// ---------------------------------------------------------------------------
`default_nettype none

module fatvcm_geom (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         wr,
  input  wire logic [fatvcm_pkg::CfgIdxW-1:0] wr_index,
  input  wire logic [31:0]                  wr_data,
  output fatvcm_pkg::geom_t                 geom
);

  logic [12:0] bps;
  logic [7:0]  spc;
  logic [15:0] reserved;
  logic [7:0]  copies;
  logic [31:0] table_size;
  logic [15:0] root_entries;
  logic [31:0] total;

  fatvcm_pkg::geom_state_e state, state_next;
  logic [4:0]  cnt;
  logic [31:0] quo;
  logic [12:0] rem;
  logic [12:0] divisor;
  logic [31:0] root;
  logic [31:0] prod;
  logic [31:0] table_base;
  logic [31:0] first_data;
  logic [31:0] clusters;
  fatvcm_pkg::kind_e kind;

  logic [13:0] rem_shift;
  logic        take;
  logic [12:0] rem_next;
  logic [31:0] quo_next;
  logic [31:0] sum_fds;
  logic        ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bps          <= fatvcm_pkg::RstBytesPerSector;
      spc          <= fatvcm_pkg::RstSectorsPerCluster;
      reserved     <= fatvcm_pkg::RstReservedSectors;
      copies       <= fatvcm_pkg::RstTableCopies;
      table_size   <= fatvcm_pkg::RstTableSizeSectors;
      root_entries <= fatvcm_pkg::RstRootEntryCount;
      total        <= fatvcm_pkg::RstTotalSectors;
    end else if (wr) begin
      case (wr_index)
        fatvcm_pkg::REG_BYTES_PER_SECTOR:    bps          <= wr_data[12:0];
        fatvcm_pkg::REG_SECTORS_PER_CLUSTER: spc          <= wr_data[7:0];
        fatvcm_pkg::REG_RESERVED_SECTORS:    reserved     <= wr_data[15:0];
        fatvcm_pkg::REG_TABLE_COPIES:        copies       <= wr_data[7:0];
        fatvcm_pkg::REG_TABLE_SIZE_SECTORS:  table_size   <= wr_data;
        fatvcm_pkg::REG_ROOT_ENTRY_COUNT:    root_entries <= wr_data[15:0];
        fatvcm_pkg::REG_TOTAL_SECTORS:       total        <= wr_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fatvcm_pkg::G_START: state_next = (bps == '0) ? fatvcm_pkg::G_MUL : fatvcm_pkg::G_ROOT;
      fatvcm_pkg::G_ROOT:  if (cnt == 5'd31) state_next = fatvcm_pkg::G_MUL;
      fatvcm_pkg::G_MUL:   state_next = fatvcm_pkg::G_SUM;
      fatvcm_pkg::G_SUM:   state_next = (spc == '0) ? fatvcm_pkg::G_KIND : fatvcm_pkg::G_CLUS;
      fatvcm_pkg::G_CLUS:  if (cnt == 5'd31) state_next = fatvcm_pkg::G_KIND;
      fatvcm_pkg::G_KIND:  state_next = fatvcm_pkg::G_DONE;
      fatvcm_pkg::G_DONE:  state_next = fatvcm_pkg::G_DONE;
      default:             state_next = fatvcm_pkg::G_START;
    endcase
  end

  // outputs and one restoring division step
  always_comb begin
    ready     = (state == fatvcm_pkg::G_DONE);
    rem_shift = {rem, quo[31]};
    take      = (rem_shift >= {1'b0, divisor});
    rem_next  = take ? 13'(rem_shift - {1'b0, divisor}) : rem_shift[12:0];
    quo_next  = {quo[30:0], take};
    sum_fds   = 32'(reserved) + prod + root;
  end

  always_ff @(posedge clk) begin
    if (rst || wr) state <= fatvcm_pkg::G_START;
    else           state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      fatvcm_pkg::G_START: begin
        quo     <= {11'd0, root_entries, 5'd0} + 32'(bps) - 32'd1;
        rem     <= '0;
        cnt     <= '0;
        divisor <= bps;
        root    <= '0;
      end
      fatvcm_pkg::G_ROOT: begin
        quo <= quo_next;
        rem <= rem_next;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) root <= quo_next;
      end
      fatvcm_pkg::G_MUL: begin
        prod       <= 32'(copies * table_size);
        table_base <= 32'(reserved) * 32'(bps);
      end
      fatvcm_pkg::G_SUM: begin
        first_data <= sum_fds;
        quo        <= total - sum_fds;
        rem        <= '0;
        cnt        <= '0;
        divisor    <= 13'(spc);
        clusters   <= '1;
      end
      fatvcm_pkg::G_CLUS: begin
        quo <= quo_next;
        rem <= rem_next;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) clusters <= quo_next;
      end
      fatvcm_pkg::G_KIND: begin
        priority if (bps == '0)                      kind <= fatvcm_pkg::KIND_EXFAT;
        else if (clusters < fatvcm_pkg::Fat12Limit) kind <= fatvcm_pkg::KIND_FAT12;
        else if (clusters < fatvcm_pkg::Fat16Limit) kind <= fatvcm_pkg::KIND_FAT16;
        else                                         kind <= fatvcm_pkg::KIND_FAT32;
      end
      fatvcm_pkg::G_DONE: ;
      default: ;
    endcase
  end

  assign geom.ready      = ready;
  assign geom.kind       = kind;
  assign geom.first_data = first_data;
  assign geom.table_base = table_base;
  assign geom.bps        = bps;
  assign geom.spc        = spc;

  a_wr_restarts: assert property (@(posedge clk) disable iff (rst)
    wr |=> !ready) else $error("geometry still ready after register write");
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    ready && !wr |=> ready) else $error("geometry ready dropped without write");
  a_fds_stable: assert property (@(posedge clk) disable iff (rst)
    ready && $past(ready) |-> $stable(first_data) && $stable(kind))
    else $error("derived geometry changed while ready");

endmodule

`default_nettype wire

FILE: hdl/fat_volume_cluster_mapper.sv
// ---------------------------------------------------------------------------
// fat_volume_cluster_mapper
// Cluster address and table word lookup for FAT12/16/32 and exFAT volumes.
// ---------------------------------------------------------------------------
// Usage:
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
//   always high. Write only while no item is in flight.
//   Items: request is taken when start is high and busy is low. action 0
//   maps request.cluster to table entry and data byte addresses; action 1
//   classifies request.table_word.
//   Results: result is shown for one cycle with strobe high, after the item
//   passes stages 1, 2 and 3. One item per cycle is taken while busy is low.
//   Busy: after reset and after every register write the geometry unit
//   recomputes root size, first data sector and cluster count through a
//   shared 32-step serial divider used at most twice, then the volume kind;
//   busy stays high until done. Pipeline: stage 1 multiply (cluster-2)*spc,
//   stage 2 add first data sector, stage 3 multiply by bytes per sector.
//   Reset: registers take their boot defaults, pipeline valid bits clear.
//   The receiver cannot stall; every result appears exactly once.
// ---------------------------------------------------------------------------
`default_nettype none

module fat_volume_cluster_mapper (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire fatvcm_pkg::req_t                 request,
  output logic                                  strobe,
  output fatvcm_pkg::res_t                      result,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [fatvcm_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [31:0]                      cfg_data
);

  fatvcm_pkg::geom_t geom;
  logic take;

  fatvcm_geom u_geom (
    .clk      (clk),
    .rst      (rst),
    .wr       (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .geom     (geom)
  );

  assign cfg_ready = 1'b1;
  assign busy      = !geom.ready;
  assign take      = start && !busy;

  // classification, stage 0 combinational
  logic [15:0] w16;
  logic [27:0] w32;
  logic [2:0]  cls0;
  logic [27:0] nxt0;

  always_comb begin
    w16  = request.table_word[15:0];
    w32  = request.table_word[27:0];
    cls0 = fatvcm_pkg::CLASS_ERROR;
    nxt0 = '0;
    if (request.action) begin
      unique case (geom.kind)
        fatvcm_pkg::KIND_FAT16: begin
          priority if (w16 == fatvcm_pkg::F16Free) cls0 = fatvcm_pkg::CLASS_FREE;
          else if (w16 >= fatvcm_pkg::F16DataLo && w16 <= fatvcm_pkg::F16DataHi) begin
            cls0 = fatvcm_pkg::CLASS_DATA;
            nxt0 = 28'(w16);
          end
          else if (w16 >= fatvcm_pkg::F16EndLo) cls0 = fatvcm_pkg::CLASS_END;
          else cls0 = fatvcm_pkg::CLASS_RESERVED;
        end
        fatvcm_pkg::KIND_FAT32: begin
          priority if (w32 == fatvcm_pkg::F32Free) cls0 = fatvcm_pkg::CLASS_FREE;
          else if (w32 >= fatvcm_pkg::F32DataLo && w32 <= fatvcm_pkg::F32DataHi) begin
            cls0 = fatvcm_pkg::CLASS_DATA;
            nxt0 = w32;
          end
          else if (w32 >= fatvcm_pkg::F32EndLo) cls0 = fatvcm_pkg::CLASS_END;
          else cls0 = fatvcm_pkg::CLASS_RESERVED;
        end
        default: cls0 = fatvcm_pkg::CLASS_ERROR;
      endcase
    end
  end

  // stage 1
  logic        v1, act1;
  logic [31:0] mul1, ent1;
  logic [2:0]  cls1;
  logic [27:0] nxt1;
  // stage 2
  logic        v2, act2;
  logic [31:0] sec2, ent2;
  logic [2:0]  cls2;
  logic [27:0] nxt2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      strobe <= 1'b0;
    end else begin
      v1     <= take;
      v2     <= v1;
      strobe <= v2;
    end
  end

  always_ff @(posedge clk) begin
    act1 <= request.action;
    mul1 <= 32'((32'(request.cluster) - 32'd2) * geom.spc);
    unique case (geom.kind)
      fatvcm_pkg::KIND_FAT16: ent1 <= {3'd0, request.cluster, 1'b0};
      fatvcm_pkg::KIND_FAT32: ent1 <= {2'd0, request.cluster, 2'b0};
      default:                ent1 <= '0;
    endcase
    cls1 <= cls0;
    nxt1 <= nxt0;

    act2 <= act1;
    sec2 <= mul1 + geom.first_data;
    ent2 <= (ent1 == '0 && act1 == 1'b0 && geom.kind != fatvcm_pkg::KIND_FAT16
             && geom.kind != fatvcm_pkg::KIND_FAT32) ? '0 : ent1 + geom.table_base;
    cls2 <= cls1;
    nxt2 <= nxt1;

    result.volume_kind   <= geom.kind;
    result.entry_address <= act2 ? '0 : ent2;
    result.data_address  <= act2 ? '0 : 32'(sec2 * geom.bps);
    result.entry_class   <= cls2;
    result.next_cluster  <= nxt2;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    take |-> ##3 strobe) else $error("item result missing after three cycles");
  a_class_no_addr: assert property (@(posedge clk) disable iff (rst)
    strobe && result.entry_class != fatvcm_pkg::CLASS_ERROR |-> result.entry_address == '0
    && result.data_address == '0) else $error("classified item carries addresses");
  a_next_only_data: assert property (@(posedge clk) disable iff (rst)
    strobe && result.entry_class != fatvcm_pkg::CLASS_DATA |-> result.next_cluster == '0)
    else $error("next cluster set for non-data class");

endmodule

`default_nettype wire

FILE: test/tb.sv
// ---------------------------------------------------------------------------
// tb
// Directed and random check of the FAT volume cluster mapper: cluster
// address lookups and table word classes across several volume geometries.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  fatvcm_pkg::req_t request = '0;
  logic strobe;
  fatvcm_pkg::res_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [fatvcm_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  fat_volume_cluster_mapper u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .strobe(strobe), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // geometry copy
  logic [12:0] g_bps;
  logic [7:0]  g_spc;
  logic [15:0] g_rsv;
  logic [7:0]  g_copies;
  logic [31:0] g_fatsz;
  logic [15:0] g_roots;
  logic [31:0] g_total;

  fatvcm_pkg::req_t item_q[$];
  fatvcm_pkg::res_t lookup_q[$];
  int   idle_pct = 0;
  bit   failed = 0;
  longint cycles = 0;

  function automatic logic [31:0] first_data_sector();
    logic [31:0] rootsz;
    rootsz = 0;
    if (g_bps != 0)
      rootsz = ({16'd0, g_roots} * 32 + {19'd0, g_bps} - 1) / {19'd0, g_bps};
    return {16'd0, g_rsv} + {24'd0, g_copies} * g_fatsz + rootsz;
  endfunction

  function automatic fatvcm_pkg::kind_e volume_kind();
    logic [31:0] clus;
    if (g_bps == 0) return fatvcm_pkg::KIND_EXFAT;
    clus = (g_spc == 0) ? 32'hFFFFFFFF :
           (g_total - first_data_sector()) / {24'd0, g_spc};
    if (clus < fatvcm_pkg::Fat12Limit) return fatvcm_pkg::KIND_FAT12;
    if (clus < fatvcm_pkg::Fat16Limit) return fatvcm_pkg::KIND_FAT16;
    return fatvcm_pkg::KIND_FAT32;
  endfunction

  function automatic fatvcm_pkg::res_t map_cluster(fatvcm_pkg::req_t rq);
    fatvcm_pkg::res_t r;
    fatvcm_pkg::kind_e k;
    logic [31:0] sec, e, c;
    r = '0;
    k = volume_kind();
    r.volume_kind = k;
    c = {4'd0, rq.cluster};
    if (rq.action == 1'b0) begin
      sec = (c - 2) * {24'd0, g_spc} + first_data_sector();
      r.data_address = sec * {19'd0, g_bps};
      if (k == fatvcm_pkg::KIND_FAT16)
        r.entry_address = {16'd0, g_rsv} * {19'd0, g_bps} + c * 2;
      else if (k == fatvcm_pkg::KIND_FAT32)
        r.entry_address = {16'd0, g_rsv} * {19'd0, g_bps} + c * 4;
    end else if (k == fatvcm_pkg::KIND_FAT16) begin
      e = {16'd0, rq.table_word[15:0]};
      if (e == fatvcm_pkg::F16Free) r.entry_class = fatvcm_pkg::CLASS_FREE;
      else if (e >= fatvcm_pkg::F16DataLo && e <= fatvcm_pkg::F16DataHi) begin
        r.entry_class = fatvcm_pkg::CLASS_DATA;
        r.next_cluster = e[27:0];
      end else if (e >= fatvcm_pkg::F16EndLo) r.entry_class = fatvcm_pkg::CLASS_END;
      else r.entry_class = fatvcm_pkg::CLASS_RESERVED;
    end else if (k == fatvcm_pkg::KIND_FAT32) begin
      e = {4'd0, rq.table_word[27:0]};
      if (e == fatvcm_pkg::F32Free) r.entry_class = fatvcm_pkg::CLASS_FREE;
      else if (e >= fatvcm_pkg::F32DataLo && e <= fatvcm_pkg::F32DataHi) begin
        r.entry_class = fatvcm_pkg::CLASS_DATA;
        r.next_cluster = e[27:0];
      end else if (e >= fatvcm_pkg::F32EndLo) r.entry_class = fatvcm_pkg::CLASS_END;
      else r.entry_class = fatvcm_pkg::CLASS_RESERVED;
    end else
      r.entry_class = fatvcm_pkg::CLASS_ERROR;
    return r;
  endfunction

  // monitor
  logic took;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    took = start && !busy && !rst;
    if (took) begin
      lookup_q.push_back(map_cluster(request));
      void'(item_q.pop_front());
    end
    if (!rst && strobe) begin
      if (lookup_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        failed = 1;
      end else begin
        fatvcm_pkg::res_t x;
        x = lookup_q.pop_front();
        if (x.volume_kind !== result.volume_kind)
          $display("%0t: volume_kind exp %0d got %0d", $time, x.volume_kind,
                   result.volume_kind);
        if (x.entry_address !== result.entry_address)
          $display("%0t: entry_address exp %h got %h", $time,
                   x.entry_address, result.entry_address);
        if (x.data_address !== result.data_address)
          $display("%0t: data_address exp %h got %h", $time, x.data_address,
                   result.data_address);
        if (x.entry_class !== result.entry_class)
          $display("%0t: entry_class exp %0d got %0d", $time, x.entry_class,
                   result.entry_class);
        if (x.next_cluster !== result.next_cluster)
          $display("%0t: next_cluster exp %h got %h", $time, x.next_cluster,
                   result.next_cluster);
        if (x !== result) failed = 1;
      end
    end
    if (cycles > 2000000) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // present the head item, idling at random; queue pops happen at posedge
  always @(negedge clk) begin
    if (rst || cfg_valid) start <= 1'b0;
    else if (item_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
      start <= 1'b1;
      request <= item_q[0];
    end else
      start <= 1'b0;
  end

  task automatic write_reg(fatvcm_pkg::reg_index_e idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      fatvcm_pkg::REG_BYTES_PER_SECTOR:    g_bps = val[12:0];
      fatvcm_pkg::REG_SECTORS_PER_CLUSTER: g_spc = val[7:0];
      fatvcm_pkg::REG_RESERVED_SECTORS:    g_rsv = val[15:0];
      fatvcm_pkg::REG_TABLE_COPIES:        g_copies = val[7:0];
      fatvcm_pkg::REG_TABLE_SIZE_SECTORS:  g_fatsz = val;
      fatvcm_pkg::REG_ROOT_ENTRY_COUNT:    g_roots = val[15:0];
      default:                             g_total = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (item_q.size() != 0 || lookup_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_volume(logic [31:0] bps, logic [31:0] spc, logic [31:0] rsv,
                            logic [31:0] cp, logic [31:0] fsz, logic [31:0] rt,
                            logic [31:0] tot);
    drain();
    write_reg(fatvcm_pkg::REG_BYTES_PER_SECTOR, bps);
    write_reg(fatvcm_pkg::REG_SECTORS_PER_CLUSTER, spc);
    write_reg(fatvcm_pkg::REG_RESERVED_SECTORS, rsv);
    write_reg(fatvcm_pkg::REG_TABLE_COPIES, cp);
    write_reg(fatvcm_pkg::REG_TABLE_SIZE_SECTORS, fsz);
    write_reg(fatvcm_pkg::REG_ROOT_ENTRY_COUNT, rt);
    write_reg(fatvcm_pkg::REG_TOTAL_SECTORS, tot);
  endtask

  function automatic fatvcm_pkg::req_t rand_item();
    fatvcm_pkg::req_t rq;
    rq.action = 1'($urandom_range(1));
    rq.cluster = 28'($urandom);
    rq.table_word = $urandom;
    case ($urandom_range(5))
      0: rq.table_word[15:0] = 16'(16'hFFF0 + $urandom_range(15));
      1: rq.table_word[27:0] = 28'(28'hFFFFFF0 + $urandom_range(15));
      2: rq.table_word[27:0] = 28'($urandom_range(3));
      3: rq.cluster = 28'($urandom_range(3));
      default: ;
    endcase
    return rq;
  endfunction

  task automatic random_phase(int n, int pct);
    idle_pct = pct;
    repeat (n) item_q.push_back(rand_item());
    drain();
  endtask

  initial begin
    fatvcm_pkg::req_t rq;
    g_bps = fatvcm_pkg::RstBytesPerSector; g_spc = fatvcm_pkg::RstSectorsPerCluster;
    g_rsv = fatvcm_pkg::RstReservedSectors; g_copies = fatvcm_pkg::RstTableCopies;
    g_fatsz = fatvcm_pkg::RstTableSizeSectors; g_roots = fatvcm_pkg::RstRootEntryCount;
    g_total = fatvcm_pkg::RstTotalSectors;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed, reset geometry (FAT12): error classes and addresses
    rq = '0; item_q.push_back(rq);
    rq.cluster = 28'hFFFFFFF; item_q.push_back(rq);
    rq = '0; rq.action = 1; rq.table_word = 32'hFFFFFFFF; item_q.push_back(rq);
    // FAT16 volume
    set_volume(512, 4, 4, 2, 200, 512, 200000);
    for (int w = 0; w < 8; w++) begin
      rq = '0; rq.action = 1;
      case (w)
        0: rq.table_word = 32'h0; 1: rq.table_word = 32'h1;
        2: rq.table_word = 32'h2; 3: rq.table_word = 32'hFFF6;
        4: rq.table_word = 32'hFFF7; 5: rq.table_word = 32'hFFF8;
        6: rq.table_word = 32'hFFFFFFFF; default: rq.table_word = 32'h12340000;
      endcase
      item_q.push_back(rq);
    end
    rq = '0; rq.cluster = 1; item_q.push_back(rq);
    // FAT32 volume, zero sectors per cluster also reaches FAT32
    set_volume(4096, 0, 65535, 255, 32'hFFFFFFFF, 65535, 32'hFFFFFFFF);
    for (int w = 0; w < 8; w++) begin
      rq = '0; rq.action = 1;
      case (w)
        0: rq.table_word = 32'hF0000000; 1: rq.table_word = 32'h1;
        2: rq.table_word = 32'h2; 3: rq.table_word = 32'h0FFFFFF6;
        4: rq.table_word = 32'hFFFFFFF7; 5: rq.table_word = 32'h0FFFFFF8;
        6: rq.table_word = 32'hFFFFFFFF; default: rq.table_word = 32'h5A5A5A5A;
      endcase
      item_q.push_back(rq);
    end
    rq = '0; rq.cluster = 28'hFFFFFFF; item_q.push_back(rq);
    // exFAT
    set_volume(0, 128, 0, 0, 0, 0, 0);
    rq = '0; rq.cluster = 28'h5555555; item_q.push_back(rq);
    rq.action = 1; item_q.push_back(rq);
    // random phases across geometries
    set_volume(512, 8, 32, 2, 8000, 0, 2000000);
    random_phase(80, 0);
    set_volume(2048, 1, 1, 1, 100, 1024, 100000);
    random_phase(80, 69);
    set_volume(512, 1, 1, 2, 9, 224, 2880);
    random_phase(80, 7);
    for (int p = 0; p < 2; p++) begin
      set_volume($urandom_range(4096), $urandom_range(1, 128), $urandom_range(65535),
                 $urandom_range(3), $urandom_range(5000), $urandom_range(65535),
                 $urandom);
      random_phase(80, p ? 69 : 0);
    end
    drain();
    if (!failed)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end
endmodule
